>>> design/twrtc_pkg.sv
// ----------------------------------------------------------------------------
// twrtc_pkg: shared types and constants of the three-wire serial master
// Phase encoding of the pin sequencer and fixed reset and limit values.
// ----------------------------------------------------------------------------
package twrtc_pkg;

  // Pin sequencer phases
  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhPre   = 3'd1,
    PhSel   = 3'd2,
    PhCmdLo = 3'd3,
    PhCmdHi = 3'd4,
    PhRdLo  = 3'd5,
    PhRdHi  = 3'd6,
    PhEnd   = 3'd7
  } phase_e;

  // Reset value of the half period register, in ticks
  localparam logic [15:0] HalfPeriodReset = 16'd48;

  // Largest number of bytes read in one transaction
  localparam logic [3:0] MaxReadBytes = 4'd8;

  // Index of the last bit in a byte
  localparam logic [2:0] LastBit = 3'd7;

endpackage

>>> design/three_wire_rtc_serial_master_unit.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_unit: bit-level three-wire serial master
// Every input item is one base tick; every result item gives the pin levels
// and any completed read byte of that tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tick item: start_req,
//   command, read_count and the sampled data pin level sio_in. The output
//   channel (out_valid_o / out_stall_i) returns exactly one result item per
//   input item, in order: chip select, serial clock, data level and drive
//   enable, a read byte with its valid and last flags, and busy.
//   The configuration port writes half_period_ticks with cfg_we_i; write it
//   only while no item is in flight.
// Pipeline and throughput:
//   An item is registered in the input stage at acceptance; its result is
//   computed by one level of logic from the sequencer state and registered
//   in the result stage when that stage can advance. One item per cycle is
//   sustained while the result side is not stalled.
// Reset: sequencer goes idle, both stages empty, half period becomes 48.
// Stall: a stalled result holds; the input register keeps one item and the
//   input side stalls only once both stages are full.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // tick item in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic [7:0]  command_i,
  input  logic [3:0]  read_count_i,
  input  logic        sio_in_i,
  // result item out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        chip_select_o,
  output logic        serial_clock_o,
  output logic        data_out_o,
  output logic        data_drive_o,
  output logic        byte_valid_o,
  output logic [7:0]  byte_data_o,
  output logic        byte_last_o,
  output logic        busy_res_o
);
  import twrtc_pkg::*;

  // Configuration
  logic [15:0] half_q;

  // Input stage
  logic       in_vld_q;
  logic       start_q;
  logic [7:0] cmd_q;
  logic [3:0] cnt_q;
  logic       sio_q;

  // Sequencer state
  phase_e      phase_q, phase_d;
  logic [15:0] hold_q, hold_d;
  logic [2:0]  bit_q, bit_d;
  logic [3:0]  left_q, left_d;
  logic [7:0]  send_q, send_d;
  logic [7:0]  recv_q, recv_d;

  // State after a start is applied
  logic        start_take;
  phase_e      ph_cur;
  logic [15:0] hold_cur;
  logic [2:0]  bit_cur;
  logic [3:0]  left_cur;
  logic [7:0]  send_cur;
  logic [7:0]  recv_cur;
  logic [7:0]  recv_set;
  logic [16:0] hold_inc;
  logic [16:0] limit;
  logic        level_end;

  // Result values of this tick
  logic       cs_c, sck_c, dout_c, drv_c, busy_c;
  logic       bvld_c, blast_c;
  logic [7:0] bdata_c;

  // Result stage
  logic       out_vld_q;
  logic       cs_q, sck_q, dout_q, drv_q, bvld_q, blast_q, busy_q;
  logic [7:0] bdata_q;

  // Handshake
  logic out_adv;
  logic step;
  logic in_acc;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_adv;
  assign in_stall_o = in_vld_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Hold the half period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfPeriodReset;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  // Input stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      start_q <= start_req_i;
      cmd_q   <= command_i;
      cnt_q   <= read_count_i;
      sio_q   <= sio_in_i;
    end
  end

  // Apply a start taken while idle
  always_comb begin
    start_take = start_q && (phase_q == PhIdle);
    ph_cur     = start_take ? PhPre : phase_q;
    hold_cur   = start_take ? 16'd0 : hold_q;
    bit_cur    = start_take ? 3'd0 : bit_q;
    send_cur   = start_take ? cmd_q : send_q;
    recv_cur   = start_take ? 8'd0 : recv_q;
    if (start_take) begin
      left_cur = (cnt_q > MaxReadBytes) ? MaxReadBytes : cnt_q;
    end else begin
      left_cur = left_q;
    end
  end

  // Decode pin levels of the current phase
  always_comb begin
    cs_c   = 1'b0;
    sck_c  = 1'b1;
    dout_c = 1'b0;
    drv_c  = 1'b0;
    busy_c = (ph_cur != PhIdle);
    case (ph_cur)
      PhPre: begin
        dout_c = 1'b1;
        drv_c  = 1'b1;
      end
      PhSel: begin
        cs_c   = 1'b1;
        dout_c = 1'b1;
        drv_c  = 1'b1;
      end
      PhCmdLo: begin
        cs_c   = 1'b1;
        sck_c  = 1'b0;
        dout_c = send_cur[7];
        drv_c  = 1'b1;
      end
      PhCmdHi: begin
        cs_c   = 1'b1;
        dout_c = send_cur[7];
        drv_c  = 1'b1;
      end
      PhRdLo: begin
        cs_c  = 1'b1;
        sck_c = 1'b0;
      end
      PhRdHi: begin
        cs_c = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Advance the sequencer at the end of each level
  always_comb begin
    hold_inc  = {1'b0, hold_cur} + 17'd1;
    limit     = (half_q == 16'd0) ? 17'd1 : {1'b0, half_q};
    level_end = (hold_inc >= limit);
    recv_set  = recv_cur | (8'(sio_q) << bit_cur);

    phase_d = ph_cur;
    hold_d  = hold_cur;
    bit_d   = bit_cur;
    left_d  = left_cur;
    send_d  = send_cur;
    recv_d  = recv_cur;
    bvld_c  = 1'b0;
    bdata_c = 8'd0;
    blast_c = 1'b0;

    if (ph_cur != PhIdle) begin
      if (!level_end) begin
        hold_d = hold_inc[15:0];
      end else begin
        hold_d = 16'd0;
        case (ph_cur)
          PhPre:   phase_d = PhSel;
          PhSel:   phase_d = PhCmdLo;
          PhCmdLo: phase_d = PhCmdHi;
          PhCmdHi: begin
            send_d = {send_cur[6:0], 1'b0};
            if (bit_cur == LastBit) begin
              bit_d   = 3'd0;
              recv_d  = 8'd0;
              phase_d = (left_cur != 4'd0) ? PhRdLo : PhEnd;
            end else begin
              bit_d   = bit_cur + 3'd1;
              phase_d = PhCmdLo;
            end
          end
          PhRdLo:  phase_d = PhRdHi;
          PhRdHi: begin
            if (bit_cur == LastBit) begin
              bvld_c  = 1'b1;
              bdata_c = recv_set;
              blast_c = (left_cur <= 4'd1);
              recv_d  = 8'd0;
              bit_d   = 3'd0;
              left_d  = (left_cur != 4'd0) ? left_cur - 4'd1 : 4'd0;
              phase_d = (left_d != 4'd0) ? PhRdLo : PhEnd;
            end else begin
              recv_d  = recv_set;
              bit_d   = bit_cur + 3'd1;
              phase_d = PhRdLo;
            end
          end
          default: phase_d = PhIdle;
        endcase
      end
    end
  end

  // Commit sequencer state once per tick item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hold_q  <= 16'd0;
      bit_q   <= 3'd0;
      left_q  <= 4'd0;
      send_q  <= 8'd0;
      recv_q  <= 8'd0;
    end else if (step) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      bit_q   <= bit_d;
      left_q  <= left_d;
      send_q  <= send_d;
      recv_q  <= recv_d;
    end
  end

  // Result stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      cs_q    <= cs_c;
      sck_q   <= sck_c;
      dout_q  <= dout_c;
      drv_q   <= drv_c;
      bvld_q  <= bvld_c;
      bdata_q <= bdata_c;
      blast_q <= blast_c;
      busy_q  <= busy_c;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign chip_select_o  = cs_q;
  assign serial_clock_o = sck_q;
  assign data_out_o     = dout_q;
  assign data_drive_o   = drv_q;
  assign byte_valid_o   = bvld_q;
  assign byte_data_o    = bdata_q;
  assign byte_last_o    = blast_q;
  assign busy_res_o     = busy_q;

  // Checks on sequencer and result consistency
  a_idle_hold_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (hold_q == 16'd0))
    else $error("hold count not clear while idle");

  a_last_needs_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && blast_q) |-> bvld_q)
    else $error("last flag without a read byte");

  a_byte_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && bvld_q) |-> (busy_q && cs_q && sck_q && !drv_q))
    else $error("read byte outside a clock-high read level");

  a_idle_pins : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !busy_q) |-> (!cs_q && sck_q && !drv_q && !dout_q))
    else $error("pins not at idle levels");

  a_step_moves_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("processed item did not reach the result stage");

endmodule

>>> tb/sv/tb_three_wire_rtc_serial_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_wire_rtc_serial_master_unit: tick-level test of the serial master
// Drives base ticks with random gaps and random result stalls. A local pin
// sequencer predicts the pin levels and read bytes of every tick, and each
// result item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_three_wire_rtc_serial_master_unit;
  import twrtc_pkg::*;

  localparam int IdleLimit    = 2000;  // cycles without any handshake
  localparam int SettleCycles = 4;     // settling wait before a register write
  localparam int DrainCycles  = 10;

  typedef struct packed {
    logic       start_req;
    logic [7:0] command;
    logic [3:0] read_count;
    logic       sio_in;
  } tick_item_t;

  typedef struct packed {
    logic       chip_select;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_last;
    logic       busy;
  } pin_levels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        start_req_i = 1'b0;
  logic [7:0]  command_i = '0;
  logic [3:0]  read_count_i = '0;
  logic        sio_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        chip_select_o;
  logic        serial_clock_o;
  logic        data_out_o;
  logic        data_drive_o;
  logic        byte_valid_o;
  logic [7:0]  byte_data_o;
  logic        byte_last_o;
  logic        busy_res_o;

  // Predicted sequencer state and register copy
  phase_e      seq_phase = PhIdle;
  logic [15:0] level_ticks = '0;
  logic [2:0]  bit_pos = '0;
  logic [3:0]  bytes_to_read = '0;
  logic [7:0]  cmd_shift = '0;
  logic [7:0]  rx_byte = '0;
  logic [15:0] half_period = HalfPeriodReset;

  pin_levels_t expected_levels_q[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_run = 0;
  int          stall_run = 0;

  three_wire_rtc_serial_master_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_req_i    (start_req_i),
    .command_i      (command_i),
    .read_count_i   (read_count_i),
    .sio_in_i       (sio_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chip_select_o  (chip_select_o),
    .serial_clock_o (serial_clock_o),
    .data_out_o     (data_out_o),
    .data_drive_o   (data_drive_o),
    .byte_valid_o   (byte_valid_o),
    .byte_data_o    (byte_data_o),
    .byte_last_o    (byte_last_o),
    .busy_res_o     (busy_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the sequencer by one tick and return the pin levels it shows
  function automatic pin_levels_t next_pin_levels(input tick_item_t item);
    pin_levels_t lv;
    logic [16:0] level_limit;
    lv = '0;
    lv.serial_clock = 1'b1;

    // Latch a new transaction only when idle
    if (seq_phase == PhIdle && item.start_req) begin
      cmd_shift     = item.command;
      bytes_to_read = (item.read_count > MaxReadBytes) ? MaxReadBytes : item.read_count;
      bit_pos       = '0;
      rx_byte       = '0;
      level_ticks   = '0;
      seq_phase     = PhPre;
    end
    lv.busy = (seq_phase != PhIdle);

    case (seq_phase)
      PhPre: begin
        lv.data_out = 1'b1;
        lv.data_drive = 1'b1;
      end
      PhSel: begin
        lv.chip_select = 1'b1;
        lv.data_out = 1'b1;
        lv.data_drive = 1'b1;
      end
      PhCmdLo: begin
        lv.chip_select = 1'b1;
        lv.serial_clock = 1'b0;
        lv.data_out = cmd_shift[7];
        lv.data_drive = 1'b1;
      end
      PhCmdHi: begin
        lv.chip_select = 1'b1;
        lv.data_out = cmd_shift[7];
        lv.data_drive = 1'b1;
      end
      PhRdLo: begin
        lv.chip_select = 1'b1;
        lv.serial_clock = 1'b0;
      end
      PhRdHi: begin
        lv.chip_select = 1'b1;
      end
      default: ;
    endcase

    // Hold the level for the half period, then step to the next one
    if (seq_phase != PhIdle) begin
      level_limit = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
      if ({1'b0, level_ticks} + 17'd1 < level_limit) begin
        level_ticks = level_ticks + 16'd1;
      end else begin
        level_ticks = '0;
        case (seq_phase)
          PhPre:   seq_phase = PhSel;
          PhSel:   seq_phase = PhCmdLo;
          PhCmdLo: seq_phase = PhCmdHi;
          PhCmdHi: begin
            cmd_shift = cmd_shift << 1;
            if (bit_pos == LastBit) begin
              bit_pos = '0;
              rx_byte = '0;
              seq_phase = (bytes_to_read != 0) ? PhRdLo : PhEnd;
            end else begin
              bit_pos = bit_pos + 3'd1;
              seq_phase = PhCmdLo;
            end
          end
          PhRdLo:  seq_phase = PhRdHi;
          PhRdHi: begin
            if (item.sio_in) rx_byte[bit_pos] = 1'b1;
            if (bit_pos == LastBit) begin
              lv.byte_valid = 1'b1;
              lv.byte_data = rx_byte;
              lv.byte_last = (bytes_to_read <= 4'd1);
              rx_byte = '0;
              bit_pos = '0;
              if (bytes_to_read != 0) bytes_to_read = bytes_to_read - 4'd1;
              seq_phase = (bytes_to_read != 0) ? PhRdLo : PhEnd;
            end else begin
              bit_pos = bit_pos + 3'd1;
              seq_phase = PhRdLo;
            end
          end
          default: seq_phase = PhIdle;
        endcase
      end
    end
    return lv;
  endfunction

  // Wait count for one item; runs of zero waits keep both sides busy at times
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(10, 50);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic tick_item_t make_tick(input logic start, input logic [7:0] cmd,
                                           input logic [3:0] cnt, input logic sio);
    tick_item_t item;
    item.start_req = start;
    item.command = cmd;
    item.read_count = cnt;
    item.sio_in = sio;
    return item;
  endfunction

  function automatic tick_item_t random_tick();
    int pick;
    logic [3:0] cnt;
    pick = $urandom_range(0, 19);
    // Favor short reads so that many frames complete
    if (pick < 12)      cnt = 4'($urandom_range(0, 2));
    else if (pick < 17) cnt = 4'($urandom_range(3, 8));
    else                cnt = 4'($urandom_range(9, 15));
    return make_tick($urandom_range(0, 2) == 0, 8'($urandom_range(0, 255)), cnt,
                     1'($urandom_range(0, 1)));
  endfunction

  // Drive one tick item, wait for its handshake and record its prediction
  task automatic send_tick(input tick_item_t item);
    int gap;
    gap = draw_wait(send_run);
    repeat (gap) @(negedge clk_i);
    in_valid_i   = 1'b1;
    start_req_i  = item.start_req;
    command_i    = item.command;
    read_count_i = item.read_count;
    sio_in_i     = item.sio_in;
    do @(posedge clk_i); while (in_stall_o);
    expected_levels_q.push_back(next_pin_levels(item));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Write the half period once every result is back and the pipe is empty
  task automatic write_half_period(input logic [15:0] ticks);
    while (expected_levels_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_wdata_i = ticks;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    half_period = ticks;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Ticks without start under the reset half period, all field extremes
  task automatic test_idle_extremes();
    send_tick(make_tick(1'b0, 8'hFF, 4'hF, 1'b1));
    send_tick(make_tick(1'b0, 8'h00, 4'h0, 1'b0));
    send_tick(make_tick(1'b0, 8'hA5, 4'h8, 1'b1));
    send_tick(make_tick(1'b0, 8'h5A, 4'h9, 1'b0));
  endtask

  // Command-only frame with start held high: restarts while busy are ignored
  task automatic test_command_only_frame();
    write_half_period(16'd1);
    repeat (19) send_tick(make_tick(1'b1, 8'hFF, 4'h0, 1'b1));
    send_tick(make_tick(1'b0, 8'h00, 4'h0, 1'b0));
  endtask

  // Oversized read count at the longest level, then shorten the level mid-way
  task automatic test_level_cut_short();
    write_half_period(16'hFFFF);
    send_tick(make_tick(1'b1, 8'h00, 4'hF, 1'b0));
    repeat (9) send_tick(make_tick(1'b0, 8'hFF, 4'h1, 1'b1));
    write_half_period(16'd1);
    repeat (150) send_tick(make_tick(1'b0, 8'($urandom_range(0, 255)),
                                     4'($urandom_range(0, 15)),
                                     1'($urandom_range(0, 1))));
  endtask

  task automatic test_random_traffic(input logic [15:0] ticks, input int count);
    write_half_period(ticks);
    repeat (count) send_tick(random_tick());
  endtask

  // Result side: stall at random, check each accepted result item
  initial begin
    pin_levels_t want;
    pin_levels_t got;
    int hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = draw_wait(stall_run);
      if (hold != 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = {chip_select_o, serial_clock_o, data_out_o, data_drive_o, byte_valid_o,
             byte_data_o, byte_last_o, busy_res_o};
      if (expected_levels_q.size() == 0) begin
        $display("%0t ns: unexpected result item, expected none, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_levels_q.pop_front();
        check_field("chip_select", 8'(want.chip_select), 8'(got.chip_select));
        check_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
        check_field("data_out", 8'(want.data_out), 8'(got.data_out));
        check_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
        check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        check_field("byte_data", want.byte_data, got.byte_data);
        check_field("byte_last", 8'(want.byte_last), 8'(got.byte_last));
        check_field("busy_res", 8'(want.busy), 8'(got.busy));
      end
      @(negedge clk_i);
    end
  end

  // Drop the run if no item moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_extremes();
    test_command_only_frame();
    test_level_cut_short();
    test_random_traffic(16'd1, 130);
    test_random_traffic(16'd2, 130);
    test_random_traffic(16'd0, 130);
    test_random_traffic(16'd1, 130);

    while (expected_levels_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && expected_levels_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/twrtc_pkg.sv
design/three_wire_rtc_serial_master_unit.sv
tb/sv/tb_three_wire_rtc_serial_master_unit.sv
